>>> hdl/dsa_pkg.sv
package dsa_pkg;

    localparam int SLOT_W   = 10;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;
    localparam int ROW_BITS = 32;
    localparam int BIT_W    = 5;

    localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 11'd1024;
    localparam logic [CNT_W-1:0] LIMIT_FLOOR     = 11'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_WRAP    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DBLFREE = 2'd2;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } ffs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE_CHECK,
        ST_FIND_BIT,
        ST_DONE
    } state_t;

endpackage

>>> hdl/dsa_ffs.sv
module dsa_ffs
    import dsa_pkg::*;
(
    input  logic [ROW_BITS-1:0] vec,
    output ffs_t                res
);

    // lowest set bit wins
    always_comb
    begin
        res.found = |vec;
        res.idx   = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                res.idx = BIT_W'(i);
            end
        end
    end

endmodule

>>> hdl/descriptor_slot_allocator_top.sv
// Flow: an accepted word is dispatched; a bump allocate or an out-of-map free goes
// straight to the result, a free first checks its bitmap row and a reuse allocate first
// searches a row for a free bit. One word at a time: requests stall until the result is
// loaded for output; the row and bit searches share the find-first-set unit.
// Reset: counters, row flags and the handshake clear at once; the bitmap
// memory needs no clearing pass since per-row valid flags mask stale rows.
module descriptor_slot_allocator_top
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp
);

    localparam int MAP_DEPTH = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
    localparam int ROWS      = (MAP_DEPTH + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TOT_W     = $clog2(MAP_DEPTH + 1);
    localparam int LIM_MAX   = (MAX_SLOTS < (1 << CNT_W) - 1) ? MAX_SLOTS : (1 << CNT_W) - 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    max_count_reg;
    logic [CNT_W-1:0]    bump_reg, bump_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [ROWS-1:0]     row_valid_reg, row_valid_next;
    logic [ROWS-1:0]     row_busy_reg, row_busy_next;

    logic                op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [SLOT_W-1:0]   res_granted_reg, res_granted_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [ROW_BITS-1:0] wr_data;

    logic [CNT_W-1:0]    limit;
    logic                reuse;
    logic                in_map;
    logic                bump_wrap;
    logic [CNT_W:0]      bump_inc;
    logic [ROW_BITS-1:0] row_word;
    logic [ROW_BITS-1:0] bit_mask;
    logic [ROW_BITS-1:0] ffs_vec;
    ffs_t                ffs_res;
    logic                rsp_load;
    logic                accept;

    dsa_ffs u_ffs
    (
        .vec (ffs_vec),
        .res (ffs_res)
    );

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // saturate the register to the legal range
    always_comb
    begin
        if (max_count_reg < LIMIT_FLOOR)
        begin
            limit = LIMIT_FLOOR;
        end
        else if (max_count_reg > CNT_W'(LIM_MAX))
        begin
            limit = CNT_W'(LIM_MAX);
        end
        else
        begin
            limit = max_count_reg;
        end
    end

    assign reuse     = (total_reg != '0) &&
                       ({{(CNT_W + 1 - TOT_W){1'b0}}, total_reg} >= {3'b000, limit[CNT_W-1:2]});
    assign in_map    = ({1'b0, slot_reg} < (SLOT_W + 1)'(MAP_DEPTH));
    assign bump_inc  = {1'b0, bump_reg} + (CNT_W + 1)'(1);
    assign bump_wrap = (bump_inc >= {1'b0, limit});
    assign row_word  = row_valid_reg[row_reg] ? rd_data_reg : '0;
    assign ffs_vec   = (state_reg == ST_FIND_BIT) ? rd_data_reg : ROW_BITS'(row_busy_reg);
    assign bit_mask  = (state_reg == ST_FIND_BIT) ? (ROW_BITS'(1) << ffs_res.idx)
                                                  : (ROW_BITS'(1) << slot_reg[BIT_W-1:0]);
    assign rsp_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (op_reg == OP_FREE)
                begin
                    state_next = in_map ? ST_FREE_CHECK : ST_DONE;
                end
                else
                begin
                    state_next = reuse ? ST_FIND_BIT : ST_DONE;
                end
            end
            ST_FREE_CHECK: state_next = ST_DONE;
            ST_FIND_BIT:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        bump_next        = bump_reg;
        total_next       = total_reg;
        row_valid_next   = row_valid_reg;
        row_busy_next    = row_busy_reg;
        row_next         = row_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        rd_en            = 1'b0;
        rd_addr          = row_reg;
        wr_en            = 1'b0;
        wr_addr          = row_reg;
        wr_data          = row_word | bit_mask;
        unique case (state_reg)
            ST_DISPATCH:
            begin
                res_status_next = STATUS_OK;
                if (op_reg == OP_FREE)
                begin
                    res_granted_next = slot_reg;
                    row_next         = slot_reg[BIT_W +: ROW_W];
                    rd_en            = in_map;
                    rd_addr          = slot_reg[BIT_W +: ROW_W];
                end
                else if (reuse)
                begin
                    // first nonempty row, read it for the bit search
                    row_next = ffs_res.idx[ROW_W-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = ffs_res.idx[ROW_W-1:0];
                end
                else
                begin
                    res_granted_next = bump_reg[SLOT_W-1:0];
                    if (bump_wrap)
                    begin
                        bump_next       = '0;
                        res_status_next = STATUS_WRAP;
                    end
                    else
                    begin
                        bump_next = bump_inc[CNT_W-1:0];
                    end
                end
            end
            ST_FREE_CHECK:
            begin
                if ((row_word & bit_mask) != '0)
                begin
                    res_status_next = STATUS_DBLFREE;
                end
                else
                begin
                    wr_en                   = 1'b1;
                    wr_data                 = row_word | bit_mask;
                    row_valid_next[row_reg] = 1'b1;
                    row_busy_next[row_reg]  = 1'b1;
                    total_next              = total_reg + TOT_W'(1);
                end
            end
            ST_FIND_BIT:
            begin
                wr_en                  = 1'b1;
                wr_data                = rd_data_reg & ~bit_mask;
                row_busy_next[row_reg] = |(rd_data_reg & ~bit_mask);
                total_next             = total_reg - TOT_W'(1);
                res_granted_next       = SLOT_W'({row_reg, ffs_res.idx});
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_count_reg <= MAX_COUNT_RESET;
            bump_reg      <= '0;
            total_reg     <= '0;
            row_valid_reg <= '0;
            row_busy_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            total_reg     <= total_next;
            row_valid_reg <= row_valid_next;
            row_busy_reg  <= row_busy_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                max_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        if (accept)
        begin
            op_reg   <= req.op;
            slot_reg <= req.slot;
        end
        if (rsp_load)
        begin
            rsp_reg.granted <= res_granted_reg;
            rsp_reg.status  <= res_status_reg;
        end
    end

    // bitmap rows
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import dsa_pkg::*;

    localparam int SLOTS        = 1024;
    localparam int REUSE_DIV    = 4;
    localparam int RANDOM_WORDS = 450;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp;

    // predictor state
    logic [CNT_W-1:0] max_count_reg = MAX_COUNT_RESET;
    int               bump_ptr      = 0;
    bit [SLOTS-1:0]   freed_map     = '0;
    int               freed_count   = 0;

    rsp_t             expected_grants[$];
    logic [SLOT_W-1:0] held_slots[$];
    int               err_count  = 0;
    bit               src_quiet  = 1'b0;
    bit               sink_quiet = 1'b0;
    int               stall_left = 0;

    descriptor_slot_allocator_top #(.MAX_SLOTS(SLOTS)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("descriptor_slot_allocator_top verification failed");
        $finish;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int limit_in_force();
        int lim;
        lim = int'(max_count_reg);
        if (lim < int'(LIMIT_FLOOR))
            lim = int'(LIMIT_FLOOR);
        if (lim > SLOTS)
            lim = SLOTS;
        return lim;
    endfunction

    // expected result word for one request; updates the slot table
    function automatic rsp_t predict_grant(req_t w);
        rsp_t r;
        int   lim;
        int   i;
        bit   found;
        r.granted = w.slot;
        r.status  = STATUS_OK;
        found     = 1'b0;
        if (w.op == OP_ALLOC)
        begin
            lim = limit_in_force();
            if (freed_count != 0 && freed_count >= lim / REUSE_DIV)
            begin
                for (i = 0; i < SLOTS && !found; i++)
                begin
                    if (freed_map[i])
                    begin
                        found        = 1'b1;
                        freed_map[i] = 1'b0;
                        freed_count--;
                        r.granted    = SLOT_W'(i);
                    end
                end
            end
            if (!found)
            begin
                r.granted = SLOT_W'(bump_ptr);
                bump_ptr++;
                if (bump_ptr >= lim)
                begin
                    bump_ptr = 0;
                    r.status = STATUS_WRAP;
                end
            end
        end
        else if (freed_map[w.slot])
            r.status = STATUS_DBLFREE;
        else
        begin
            freed_map[w.slot] = 1'b1;
            freed_count++;
        end
        return r;
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
        end
        else if (sink_quiet || $urandom_range(0, 2) != 0)
            rsp_stall <= 1'b0;
        else
        begin
            rsp_stall  <= 1'b1;
            stall_left <= pick_gap(1'b0);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("unexpected result word: granted %0d status %0d",
                       rsp.granted, rsp.status);
                err_count++;
            end
            else
            begin
                want = expected_grants.pop_front();
                if (rsp.granted !== want.granted)
                begin
                    $error("granted: expected %0d, got %0d", want.granted, rsp.granted);
                    err_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    err_count++;
                end
            end
        end
    end

    task automatic send_word(input logic o, input logic [SLOT_W-1:0] s, output rsp_t pred);
        req_t w;
        int   gap;
        w.op   = o;
        w.slot = s;
        gap    = pick_gap(src_quiet);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = predict_grant(w);
        expected_grants.push_back(pred);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_count(input logic [CNT_W-1:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we        <= 1'b0;
        max_count_reg  = v;
    endtask

    task automatic test_bump_after_reset();
        rsp_t got;
        repeat (6)
            send_word(OP_ALLOC, SLOT_W'($urandom), got);
    endtask

    // limit below the floor while the bump pointer already sits above it
    task automatic test_lowered_limit();
        rsp_t got;
        write_max_count(11'd2);
        repeat (5)
            send_word(OP_ALLOC, SLOT_W'($urandom), got);
    endtask

    task automatic test_free_and_reuse();
        rsp_t got;
        send_word(OP_FREE, 10'd0, got);
        send_word(OP_FREE, 10'd0, got);
        send_word(OP_FREE, 10'd1023, got);
        send_word(OP_ALLOC, 10'd1023, got);
        send_word(OP_ALLOC, 10'd0, got);
    endtask

    task automatic test_upper_limits();
        rsp_t got;
        write_max_count(11'd2047);
        send_word(OP_FREE, 10'd1, got);
        send_word(OP_ALLOC, 10'd0, got);
        write_max_count(11'd1025);
        send_word(OP_ALLOC, 10'd0, got);
        write_max_count(11'd4);
        send_word(OP_ALLOC, 10'd0, got);
        send_word(OP_ALLOC, 10'd0, got);
        write_max_count(11'd0);
        send_word(OP_ALLOC, 10'd0, got);
        write_max_count(MAX_COUNT_RESET);
        send_word(OP_ALLOC, 10'd0, got);
    endtask

    task automatic test_random_traffic();
        rsp_t             got;
        int               sent;
        int               phase;
        int               n;
        int               k;
        int               lim;
        logic [CNT_W-1:0] v;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            case (phase)
                0:       v = 11'd4;
                1:       v = 11'd7;
                2:       v = 11'd64;
                3:       v = 11'd1024;
                4:       v = 11'd3;
                5:       v = 11'd2047;
                6:       v = 11'd33;
                7:       v = 11'd1100;
                default: v = ($urandom_range(0, 2) == 0) ? CNT_W'($urandom_range(0, 2047))
                                                         : CNT_W'($urandom_range(4, 128));
            endcase
            write_max_count(v);
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            lim        = limit_in_force();
            n          = $urandom_range(25, 50);
            repeat (n)
            begin
                k = $urandom_range(0, 99);
                if (k < 50 || (k < 85 && held_slots.size() == 0))
                begin
                    send_word(OP_ALLOC, SLOT_W'($urandom), got);
                    held_slots.push_back(got.granted);
                end
                else if (k < 85)
                begin
                    // return a slot that was handed out earlier
                    k = $urandom_range(0, held_slots.size() - 1);
                    send_word(OP_FREE, held_slots[k], got);
                    held_slots.delete(k);
                end
                else if (k < 93)
                    send_word(OP_FREE, SLOT_W'($urandom_range(0, lim - 1)), got);
                else
                    send_word(OP_FREE, SLOT_W'($urandom), got);
                sent++;
            end
            phase++;
        end
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
    endtask

    task automatic finish_run();
        wait_idle();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("descriptor_slot_allocator_top verification clean");
        else
            $display("descriptor_slot_allocator_top verification failed");
        $finish;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_bump_after_reset();
        test_lowered_limit();
        test_free_and_reuse();
        test_upper_limits();
        test_random_traffic();
        finish_run();
    end

endmodule
